/* hdl/head_len_tail_frame_parser_assert.svh */
`ifndef HEAD_LEN_TAIL_FRAME_PARSER_ASSERT_SVH
`define HEAD_LEN_TAIL_FRAME_PARSER_ASSERT_SVH

// Clocked assertion with an explicit clock and active-low reset.
`define HLTFP_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same, on the block clock and reset.
`define HLTFP_ASSERT(label, prop, msg) \
  `HLTFP_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* hdl/hltfp_pkg.sv */
package hltfp_pkg;

  localparam logic [7:0] HdrA  = 8'hFF;
  localparam logic [7:0] HdrB  = 8'hEE;
  localparam logic [7:0] TailA = 8'hEE;
  localparam logic [7:0] TailB = 8'hFF;

  typedef enum logic [4:0] {
    PhHunt = 5'b00001,
    PhLen  = 5'b00010,
    PhPay  = 5'b00100,
    PhT1   = 5'b01000,
    PhT2   = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    logic       tail_good;
  } res_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

/* hdl/hltfp_in_if.sv */
interface hltfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

/* hdl/hltfp_out_if.sv */
interface hltfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;
  logic       tail_good;

  modport source (output valid, output out_byte, output frame_end, output tail_good,
                  input ready);
  modport sink (input valid, input out_byte, input frame_end, input tail_good,
                output ready);
endinterface

/* hdl/hltfp_parse.sv */
module hltfp_parse import hltfp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] byte_i,
  output push_t      push_o,
  output res_t       res0_o,
  output res_t       res1_o
);

  phase_e     phase_q, phase_d;
  logic       last_ff_q, last_ff_d;
  logic [7:0] left_q, left_d;
  logic       tail_ok_q, tail_ok_d;
  push_t      push;

  always_comb begin
    phase_d   = phase_q;
    last_ff_d = last_ff_q;
    left_d    = left_q;
    tail_ok_d = tail_ok_q;
    push      = '0;
    res0_o    = '{out_byte: byte_i, frame_end: 1'b0, tail_good: 1'b0};
    res1_o    = '{out_byte: HdrB, frame_end: 1'b0, tail_good: 1'b0};
    case (phase_q)
      PhLen: begin
        push.first = 1'b1;
        left_d     = byte_i;
        phase_d    = (byte_i != 8'd0) ? PhPay : PhT1;
      end
      PhPay: begin
        push.first = 1'b1;
        left_d     = left_q - 8'd1;
        if (left_q == 8'd1) begin
          phase_d = PhT1;
        end
      end
      PhT1: begin
        push.first = 1'b1;
        tail_ok_d  = (byte_i == TailA);
        phase_d    = PhT2;
      end
      PhT2: begin
        push.first       = 1'b1;
        res0_o.frame_end = 1'b1;
        res0_o.tail_good = tail_ok_q && (byte_i == TailB);
        phase_d          = PhHunt;
        last_ff_d        = 1'b0;
        tail_ok_d        = 1'b0;
      end
      default: begin
        if (last_ff_q && (byte_i == HdrB)) begin
          push.first      = 1'b1;
          push.second     = 1'b1;
          res0_o.out_byte = HdrA;
          last_ff_d       = 1'b0;
          phase_d         = PhLen;
        end else begin
          last_ff_d = (byte_i == HdrA);
          phase_d   = PhHunt;
        end
      end
    endcase
  end

  assign push_o = beat_i ? push : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      last_ff_q <= 1'b0;
      left_q    <= 8'd0;
      tail_ok_q <= 1'b0;
    end else if (beat_i) begin
      phase_q   <= phase_d;
      last_ff_q <= last_ff_d;
      left_q    <= left_d;
      tail_ok_q <= tail_ok_d;
    end
  end

endmodule

/* hdl/hltfp_queue.sv */
module hltfp_queue import hltfp_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  res_t  res0_i,
  input  res_t  res1_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output res_t  head_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  res_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, wr_d, wr_nxt, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign wr_nxt  = inc(wr_q);
  assign full_o  = cnt_q > CW'(DEPTH - 2);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    if (push_i.first) begin
      wr_d = push_i.second ? inc(wr_nxt) : wr_nxt;
    end
    rd_d  = pop_i ? inc(rd_q) : rd_q;
    cnt_d = cnt_q + CW'(push_i.first) + CW'(push_i.second) - CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wr_nxt] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* hdl/head_len_tail_frame_parser.sv */
// Byte-stream deframer: hunts for header FF EE, then passes the length byte L, L payload
// bytes and two tail bytes, one output beat per frame byte; the final tail beat has
// frame_end set and tail_good set only if the tail was EE FF, so the consumer drops frames
// ending with tail_good low. One input beat is taken every cycle while ready is high; each
// beat goes through the parser state update in the same cycle and its results are registered
// into an OUT_DEPTH-entry result queue, whose head is offered on the output. The beat that
// completes a header yields two results, and input ready drops only while the queue holds
// more than OUT_DEPTH-2 results; at OUT_DEPTH 4 that happens only on an output stall.
module head_len_tail_frame_parser import hltfp_pkg::*; #(
  parameter int unsigned OUT_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  hltfp_in_if.sink   in_i,
  hltfp_out_if.source out_o
);

  logic  beat;
  logic  pop;
  logic  full;
  logic  head_valid;
  push_t push;
  res_t  res0, res1, head;

  assign in_i.ready = !full;
  assign beat       = in_i.valid && !full;
  assign pop        = head_valid && out_o.ready;

  hltfp_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .beat_i (beat),
    .byte_i (in_i.in_byte),
    .push_o (push),
    .res0_o (res0),
    .res1_o (res1)
  );

  hltfp_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (head_valid),
    .head_o  (head)
  );

  assign out_o.valid     = head_valid;
  assign out_o.out_byte  = head.out_byte;
  assign out_o.frame_end = head.frame_end;
  assign out_o.tail_good = head.tail_good;

endmodule

/* hdl/hltfp_checker.sv */
`include "head_len_tail_frame_parser_assert.svh"

module hltfp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  hltfp_in_if.sink    in_i,
  hltfp_out_if.source out_o
);

  // tail_good only ever rides on the closing beat
  `HLTFP_ASSERT(a_good_on_end, out_o.valid && !out_o.frame_end |-> !out_o.tail_good, "tail_good without frame_end")

  // back-pressure on the input only while results are waiting
  `HLTFP_ASSERT(a_stall_has_data, !in_i.ready |-> out_o.valid, "input stalled with empty output")

  // hold a stalled output beat
  `HLTFP_ASSERT(a_out_hold, out_o.valid && !out_o.ready |=> out_o.valid && $stable(out_o.out_byte) && $stable(out_o.frame_end) && $stable(out_o.tail_good), "stalled output beat changed")

endmodule

bind head_len_tail_frame_parser hltfp_checker u_hltfp_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .in_i   (in_i),
  .out_o  (out_o)
);

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import hltfp_pkg::*;

  class frame_scoreboard;
    res_t       frame_beats_q[$];
    phase_e     phase         = PhHunt;
    logic       last_was_ff   = 1'b0;
    logic [8:0] bytes_left    = '0;
    logic       tail_first_ok = 1'b0;
    int         errors        = 0;

    function void push_beat(logic [7:0] b, logic fend, logic good);
      res_t r;
      r.out_byte  = b;
      r.frame_end = fend;
      r.tail_good = good;
      frame_beats_q.push_back(r);
    endfunction

    function void note_in_byte(logic [7:0] b);
      case (phase)
        PhLen: begin
          push_beat(b, 1'b0, 1'b0);
          bytes_left = {1'b0, b};
          phase = (b != 8'h00) ? PhPay : PhT1;
        end
        PhPay: begin
          push_beat(b, 1'b0, 1'b0);
          bytes_left = bytes_left - 9'd1;
          if (bytes_left == 9'd0) phase = PhT1;
        end
        PhT1: begin
          push_beat(b, 1'b0, 1'b0);
          tail_first_ok = (b == TailA);
          phase = PhT2;
        end
        PhT2: begin
          push_beat(b, 1'b1, tail_first_ok && (b == TailB));
          phase = PhHunt;
          last_was_ff = 1'b0;
          tail_first_ok = 1'b0;
        end
        default: begin
          if (last_was_ff && b == HdrB) begin
            push_beat(HdrA, 1'b0, 1'b0);
            push_beat(HdrB, 1'b0, 1'b0);
            last_was_ff = 1'b0;
            phase = PhLen;
          end else begin
            last_was_ff = (b == HdrA);
            phase = PhHunt;
          end
        end
      endcase
    endfunction

    function void check_out_beat(res_t got);
      res_t want;
      if (frame_beats_q.size() == 0) begin
        $display("%0t: unexpected beat, actual byte=%h end=%b good=%b",
                 $time, got.out_byte, got.frame_end, got.tail_good);
        errors++;
        return;
      end
      want = frame_beats_q.pop_front();
      if (got.out_byte !== want.out_byte) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
        errors++;
      end
      if (got.frame_end !== want.frame_end) begin
        $display("%0t: frame_end expected %b actual %b", $time, want.frame_end, got.frame_end);
        errors++;
      end
      if (got.tail_good !== want.tail_good) begin
        $display("%0t: tail_good expected %b actual %b", $time, want.tail_good, got.tail_good);
        errors++;
      end
    endfunction

    function int pending();
      return frame_beats_q.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  hltfp_in_if  in_bus ();
  hltfp_out_if out_bus ();

  head_len_tail_frame_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  frame_scoreboard sb = new();

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int frame_bytes    = 0;

  logic [7:0] directed_bytes [27] = '{
    8'h00, 8'hFF, 8'h7F,
    8'hFF, 8'hEE, 8'h00, 8'hEE, 8'hFF,
    8'hFF, 8'hFF, 8'hEE, 8'h01, 8'hA5, 8'hEE, 8'hFF,
    8'hFF, 8'hEE, 8'h02, 8'hFF, 8'hEE, 8'hEE, 8'h00,
    8'hFF, 8'hEE, 8'h00, 8'h12, 8'hFF
  };

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    res_t got;
    if (rst_ni) begin
      if (in_bus.valid && in_bus.ready) sb.note_in_byte(in_bus.in_byte);
      if (out_bus.valid && out_bus.ready) begin
        got.out_byte  = out_bus.out_byte;
        got.frame_end = out_bus.frame_end;
        got.tail_good = out_bus.tail_good;
        sb.check_out_beat(got);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_bus.valid   <= 1'b1;
    in_bus.in_byte <= b;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] payload_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'hFF;
    if (r == 1) return 8'hEE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_frame();
    int         noise_len;
    int         kind;
    logic [7:0] len;
    noise_len = $urandom_range(0, 3);
    repeat (noise_len) send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      send_byte(HdrA);
      send_byte(payload_byte());
      return;
    end
    if ($urandom_range(0, 99) < 2) len = 8'hFF;
    else len = 8'($urandom_range(0, 6));
    send_byte(HdrA);
    send_byte(HdrB);
    send_byte(len);
    for (int i = 0; i < len; i++) send_byte(payload_byte());
    if (kind < 85) begin
      send_byte(TailA);
      send_byte(TailB);
    end else begin
      send_byte(($urandom_range(0, 1) == 0) ? TailA : payload_byte());
      send_byte(payload_byte());
    end
    frame_bytes += 5 + len;
  endtask

  initial begin
    #2_000_000;
    $display("[head_len_tail_frame_parser] ERROR");
    $finish;
  end

  initial begin
    rst_ni         <= 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.in_byte <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      frame_bytes = 0;
      while (frame_bytes < 250) send_random_frame();
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[head_len_tail_frame_parser] OK");
    end else begin
      $display("[head_len_tail_frame_parser] ERROR");
    end
    $finish;
  end

endmodule
